@@ rtl/gjdc_pkg.sv @@
// ----------------------------------------------------------------------------
// gjdc_pkg
// Shared types, status codes and fixed-point constants for the Gregorian date
// and Julian Day Number converter.
// ----------------------------------------------------------------------------
package gjdc_pkg;

   // Register stages from accepted beat to result register
   localparam int unsigned STAGES = 8;

   localparam int unsigned MAX_YEAR_DEF = 9999;

   // Conversion kinds
   localparam logic KIND_TO_JDN   = 1'b0;
   localparam logic KIND_FROM_JDN = 1'b1;

   // Result status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_YEAR   = 3'd1;
   localparam logic [2:0] ST_BAD_MONTH  = 3'd2;
   localparam logic [2:0] ST_BAD_DAY    = 3'd3;
   localparam logic [2:0] ST_BAD_DAYNUM = 3'd4;

   // Day number of 1 January, year 1
   localparam logic [22:0] LO_DN = 23'd1721426;

   // Reciprocals for exact division by constants: q = (x * MUL) >> SHIFT,
   // with MUL = ceil(2^SHIFT / D) and SHIFT = bits(x) + bits(D).
   localparam int unsigned Y100_SHIFT = 21;
   localparam logic [14:0] Y100_MUL =
      15'(((64'd1 << Y100_SHIFT) + 64'd99) / 64'd100);

   // 4*l / 146097, with the factor 4 folded into the multiplier
   localparam int unsigned N_SHIFT = 44;
   localparam logic [28:0] N_MUL4 =
      29'(64'd4 * (((64'd1 << N_SHIFT) + 64'd146096) / 64'd146097));

   // x / 1461001
   localparam int unsigned I_SHIFT = 49;
   localparam logic [28:0] I_MUL =
      29'(((64'd1 << I_SHIFT) + 64'd1461000) / 64'd1461001);

   // 80*l / 2447, with the factor 80 folded into the multiplier
   localparam int unsigned J_SHIFT = 28;
   localparam logic [23:0] J_MUL80 =
      24'(64'd80 * (((64'd1 << J_SHIFT) + 64'd2446) / 64'd2447));

   typedef struct packed {
      logic [22:0] day_number;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [2:0]  status;
   } res_type;

   // Days in a month; zero for month codes that name no month
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month) inside
         4'd2:                                  len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:               len = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         default:                               len = 5'd0;
      endcase
      return len;
   endfunction

   // (367 * (month - 2 - 12*a)) / 12, with a = -1 for January and February
   function automatic logic [8:0] month_days(input logic [3:0] month);
      logic [8:0] days;
      case (month)
         4'd1:    days = 9'd336;
         4'd2:    days = 9'd367;
         4'd3:    days = 9'd30;
         4'd4:    days = 9'd61;
         4'd5:    days = 9'd91;
         4'd6:    days = 9'd122;
         4'd7:    days = 9'd152;
         4'd8:    days = 9'd183;
         4'd9:    days = 9'd214;
         4'd10:   days = 9'd244;
         4'd11:   days = 9'd275;
         4'd12:   days = 9'd305;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   // (2447 * j) / 80
   function automatic logic [8:0] month_offset(input logic [4:0] j);
      logic [8:0] offs;
      case (j)
         5'd1:    offs = 9'd30;
         5'd2:    offs = 9'd61;
         5'd3:    offs = 9'd91;
         5'd4:    offs = 9'd122;
         5'd5:    offs = 9'd152;
         5'd6:    offs = 9'd183;
         5'd7:    offs = 9'd214;
         5'd8:    offs = 9'd244;
         5'd9:    offs = 9'd275;
         5'd10:   offs = 9'd305;
         5'd11:   offs = 9'd336;
         5'd12:   offs = 9'd367;
         5'd13:   offs = 9'd397;
         5'd14:   offs = 9'd428;
         5'd15:   offs = 9'd458;
         5'd16:   offs = 9'd489;
         default: offs = 9'd0;
      endcase
      return offs;
   endfunction

endpackage

@@ rtl/gregorian_julian_day_converter_core.sv @@
// ----------------------------------------------------------------------------
// gregorian_julian_day_converter_core
// Converts a Gregorian date to a Julian Day Number or back, one request per
// beat, with field and range checks that report a status code.
//
//   channel   ports                                         direction
//   req       req_valid req_stall req_kind req_year          in
//             req_month req_day req_day_number
//   rsp       rsp_valid rsp_stall rsp_out_day_number          out
//             rsp_out_year rsp_out_month rsp_out_day rsp_status
//
// Eight register stages; one beat can enter every cycle while req_stall is low.
// The depth is set by the day number inversion, a chain of reciprocal
// multiplies, at most one multiplier per stage.
// Each stage loads when it is empty or the stage after it moves, so a rsp
// stall backs up stage by stage and bubbles close up.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module gregorian_julian_day_converter_core #(
   parameter int unsigned MAX_YEAR = gjdc_pkg::MAX_YEAR_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [13:0] req_year,
   input  logic [3:0]  req_month,
   input  logic [4:0]  req_day,
   input  logic [22:0] req_day_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [22:0] rsp_out_day_number,
   output logic [13:0] rsp_out_year,
   output logic [3:0]  rsp_out_month,
   output logic [4:0]  rsp_out_day,
   output logic [2:0]  rsp_status
);

   localparam int unsigned Last = gjdc_pkg::STAGES - 1;

   logic [Last:0]     valid_ff;
   logic [Last:0]     ready;
   logic [Last-1:0]   kind_ff;
   gjdc_pkg::res_type fwd_res;
   gjdc_pkg::res_type inv_res;
   gjdc_pkg::res_type sel;
   gjdc_pkg::res_type out_in;
   gjdc_pkg::res_type out_ff;

   gjdc_to_jdn #(
      .MAX_YEAR (MAX_YEAR)
   ) u_to_jdn (
      .clock (clock),
      .en    (ready[Last-1:0]),
      .year  (req_year),
      .month (req_month),
      .day   (req_day),
      .res   (fwd_res)
   );

   gjdc_from_jdn #(
      .MAX_YEAR (MAX_YEAR)
   ) u_from_jdn (
      .clock      (clock),
      .en         (ready[Last-1:0]),
      .day_number (req_day_number),
      .res        (inv_res)
   );

   // A stage may load when it is empty or its contents move on
   always_comb begin
      ready[Last] = !valid_ff[Last] || !rsp_stall;
      for (int k = Last - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   assign req_stall = !ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k <= Last; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         kind_ff[0] <= req_kind;
      end
      for (int k = 1; k < Last; k++) begin
         if (ready[k]) begin
            kind_ff[k] <= kind_ff[k-1];
         end
      end
      if (ready[Last]) begin
         out_ff <= out_in;
      end
   end

   // Pick the direction, drop all result fields on an error
   always_comb begin
      sel    = (kind_ff[Last-1] == gjdc_pkg::KIND_FROM_JDN) ? inv_res : fwd_res;
      out_in = sel;
      if (sel.status != gjdc_pkg::ST_OK) begin
         out_in        = '0;
         out_in.status = sel.status;
      end
   end

   assign rsp_valid          = valid_ff[Last];
   assign rsp_out_day_number = out_ff.day_number;
   assign rsp_out_year       = out_ff.year;
   assign rsp_out_month      = out_ff.month;
   assign rsp_out_day        = out_ff.day;
   assign rsp_status         = out_ff.status;

`ifndef SYNTHESIS
   a_accept_lands : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[0])
      else $error("accepted beat did not enter the first stage");

   a_full_backs_up : assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && rsp_stall |-> req_stall)
      else $error("full pipeline took a beat while the result was stalled");

   a_error_zeroed : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != gjdc_pkg::ST_OK |->
         rsp_out_day_number == 23'd0 && rsp_out_year == 14'd0 &&
         rsp_out_month == 4'd0 && rsp_out_day == 5'd0)
      else $error("error result carries nonzero fields");

   a_ok_date_sane : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == gjdc_pkg::ST_OK |->
         rsp_out_month != 4'd0 && rsp_out_month <= 4'd12 && rsp_out_day != 5'd0)
      else $error("good result holds an impossible month or day");
`endif

endmodule

@@ rtl/gjdc_to_jdn.sv @@
// ----------------------------------------------------------------------------
// gjdc_to_jdn
// Date to day number datapath: field checks, leap rule and the day number sum
// in four stages, then delay stages to line up with the inverse path.
// ----------------------------------------------------------------------------
module gjdc_to_jdn #(
   parameter int unsigned MAX_YEAR = gjdc_pkg::MAX_YEAR_DEF
) (
   input  logic                           clock,
   input  logic [gjdc_pkg::STAGES-2:0]    en,
   input  logic [13:0]                    year,
   input  logic [3:0]                     month,
   input  logic [4:0]                     day,
   output gjdc_pkg::res_type              res
);

   localparam logic [15:0] MaxYr = 16'(MAX_YEAR);

   // stage 0
   logic [13:0] year_ff [0:2];
   logic [3:0]  month_ff [0:2];
   logic [4:0]  day_ff [0:2];
   logic [2:0]  st_ff [0:2];
   logic        early_ff [0:1];
   logic [28:0] yprod_ff;
   logic [2:0]  st0_in;
   logic [28:0] yprod_in;

   // stage 1
   logic [7:0]  cent;
   logic [6:0]  rem;
   logic        leap;
   logic [4:0]  len;
   logic [2:0]  st1_in;
   logic [7:0]  qa_in;
   logic [7:0]  qa_ff;

   // stage 2
   logic [14:0] ybase;
   logic [24:0] t1prod;
   logic [9:0]  t3prod;
   logic [22:0] t1_ff;
   logic [8:0]  t2_ff;
   logic [7:0]  t3_ff;

   // stage 3 and delay
   logic [23:0]       jdn_sum;
   gjdc_pkg::res_type res3_in;
   gjdc_pkg::res_type res_ff [3:6];

   always_comb begin
      yprod_in = {15'd0, year} * {14'd0, gjdc_pkg::Y100_MUL};
      if (year == 14'd0 || {2'b00, year} > MaxYr) begin
         st0_in = gjdc_pkg::ST_BAD_YEAR;
      end else if (month == 4'd0 || month > 4'd12) begin
         st0_in = gjdc_pkg::ST_BAD_MONTH;
      end else begin
         st0_in = gjdc_pkg::ST_OK;
      end
   end

   always_comb begin
      cent  = yprod_ff[28:21];
      rem   = 7'(year_ff[0] - 14'({6'd0, cent} * 14'd100));
      leap  = (year_ff[0][1:0] == 2'd0 && rem != 7'd0) ||
              (rem == 7'd0 && cent[1:0] == 2'd0);
      len   = gjdc_pkg::month_len(month_ff[0], leap);
      // (y + a) / 100 drops by one in a century year when a = -1
      qa_in = (early_ff[0] && rem == 7'd0) ? cent - 8'd1 : cent;
      st1_in = st_ff[0];
      if (st_ff[0] == gjdc_pkg::ST_OK && (day_ff[0] == 5'd0 || day_ff[0] > len)) begin
         st1_in = gjdc_pkg::ST_BAD_DAY;
      end
   end

   always_comb begin
      ybase  = {1'b0, year_ff[1]} + 15'd4800 - {14'd0, early_ff[1]};
      t1prod = {10'd0, ybase} * 25'd1461;
      t3prod = ({2'd0, qa_ff} + 10'd49) * 10'd3;
   end

   always_comb begin
      jdn_sum = {1'b0, t1_ff} + {15'd0, t2_ff} + {19'd0, day_ff[2]}
              - {16'd0, t3_ff} - 24'd32075;
      res3_in.day_number = jdn_sum[22:0];
      res3_in.year       = year_ff[2];
      res3_in.month      = month_ff[2];
      res3_in.day        = day_ff[2];
      res3_in.status     = st_ff[2];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         year_ff[0]  <= year;
         month_ff[0] <= month;
         day_ff[0]   <= day;
         st_ff[0]    <= st0_in;
         early_ff[0] <= (month < 4'd3);
         yprod_ff    <= yprod_in;
      end
      if (en[1]) begin
         year_ff[1]  <= year_ff[0];
         month_ff[1] <= month_ff[0];
         day_ff[1]   <= day_ff[0];
         st_ff[1]    <= st1_in;
         early_ff[1] <= early_ff[0];
         qa_ff       <= qa_in;
      end
      if (en[2]) begin
         year_ff[2]  <= year_ff[1];
         month_ff[2] <= month_ff[1];
         day_ff[2]   <= day_ff[1];
         st_ff[2]    <= st_ff[1];
         t1_ff       <= t1prod[24:2];
         t2_ff       <= gjdc_pkg::month_days(month_ff[1]);
         t3_ff       <= t3prod[9:2];
      end
      if (en[3]) begin
         res_ff[3] <= res3_in;
      end
      for (int k = 4; k <= 6; k++) begin
         if (en[k]) begin
            res_ff[k] <= res_ff[k-1];
         end
      end
   end

   assign res = res_ff[6];

endmodule

@@ rtl/gjdc_from_jdn.sv @@
// ----------------------------------------------------------------------------
// gjdc_from_jdn
// Day number to date datapath: range check and the integer inversion, one
// reciprocal multiply or one constant multiply and subtract per stage.
// ----------------------------------------------------------------------------
module gjdc_from_jdn #(
   parameter int unsigned MAX_YEAR = gjdc_pkg::MAX_YEAR_DEF
) (
   input  logic                           clock,
   input  logic [gjdc_pkg::STAGES-2:0]    en,
   input  logic [22:0]                    day_number,
   output gjdc_pkg::res_type              res
);

   // Day number of 31 December of the last year
   localparam longint HiDn = (64'sd1461 * (longint'(MAX_YEAR) + 64'sd4800)) / 4
                           + 305 - (3 * ((longint'(MAX_YEAR) + 64'sd4900) / 100)) / 4
                           + 31 - 32075;
   localparam logic [24:0] HiDnV = 25'(HiDn);

   logic [22:0] dn_ff [0:6];
   logic        bad_ff [0:6];
   logic [23:0] l_ff [0:1];
   logic [52:0] pn_ff;
   logic [8:0]  n_ff [2:6];
   logic [15:0] l2_ff [2:4];
   logic [27:0] x_ff;
   logic [56:0] pi_ff;
   logic [7:0]  i_ff [5:6];
   logic [8:0]  l3_ff [5:6];
   logic [32:0] pj_ff;

   logic [26:0] nday;
   logic [24:0] l2w;
   logic [7:0]  iq;
   logic [18:0] iprod;
   logic [16:0] l3w;
   logic [4:0]  j;
   logic        l4;
   logic [8:0]  dw;
   logic [15:0] yw;

   always_comb begin
      nday  = {18'd0, pn_ff[52:44]} * 27'd146097 + 27'd3;
      l2w   = {1'b0, l_ff[1]} - nday[26:2];
      iq    = pi_ff[56:49];
      iprod = {11'd0, iq} * 19'd1461;
      l3w   = {1'b0, l2_ff[4]} - iprod[18:2] + 17'd31;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dn_ff[0]  <= day_number;
         bad_ff[0] <= (day_number < gjdc_pkg::LO_DN) || ({2'b00, day_number} > HiDnV);
         l_ff[0]   <= {1'b0, day_number} + 24'd68569;
      end
      for (int k = 1; k <= 6; k++) begin
         if (en[k]) begin
            dn_ff[k]  <= dn_ff[k-1];
            bad_ff[k] <= bad_ff[k-1];
         end
      end
      if (en[1]) begin
         l_ff[1] <= l_ff[0];
         pn_ff   <= {29'd0, l_ff[0]} * {24'd0, gjdc_pkg::N_MUL4};
      end
      if (en[2]) begin
         n_ff[2]  <= pn_ff[52:44];
         l2_ff[2] <= l2w[15:0];
      end
      if (en[3]) begin
         n_ff[3]  <= n_ff[2];
         l2_ff[3] <= l2_ff[2];
         x_ff     <= ({12'd0, l2_ff[2]} + 28'd1) * 28'd4000;
      end
      if (en[4]) begin
         n_ff[4]  <= n_ff[3];
         l2_ff[4] <= l2_ff[3];
         pi_ff    <= {29'd0, x_ff} * {28'd0, gjdc_pkg::I_MUL};
      end
      if (en[5]) begin
         n_ff[5]  <= n_ff[4];
         i_ff[5]  <= iq;
         l3_ff[5] <= l3w[8:0];
      end
      if (en[6]) begin
         n_ff[6]  <= n_ff[5];
         i_ff[6]  <= i_ff[5];
         l3_ff[6] <= l3_ff[5];
         pj_ff    <= {24'd0, l3_ff[5]} * {9'd0, gjdc_pkg::J_MUL80};
      end
   end

   // Final step feeds the result register in the top level
   always_comb begin
      j  = pj_ff[32:28];
      l4 = (j >= 5'd11);
      dw = l3_ff[6] - gjdc_pkg::month_offset(j);
      yw = 16'({7'd0, n_ff[6]} * 16'd100) + {8'd0, i_ff[6]} + {15'd0, l4} - 16'd4900;
      res.day_number = dn_ff[6];
      res.year       = yw[13:0];
      res.month      = l4 ? 4'(j - 5'd10) : 4'(j + 5'd2);
      res.day        = dw[4:0];
      res.status     = bad_ff[6] ? gjdc_pkg::ST_BAD_DAYNUM : gjdc_pkg::ST_OK;
   end

endmodule

@@ dv/gregorian_julian_day_converter_core_test.sv @@
// ----------------------------------------------------------------------------
// gregorian_julian_day_converter_core_test
// Self-checking bench for the date / Julian Day Number converter. A short
// table of directed beats covers field extremes, range edges, leap days and
// every status code. A random mix of well-formed dates, in-range day numbers
// and raw field noise follows. Results are checked against table values or a local
// calendar model, with bursty request traffic and a stalling result side.
// ----------------------------------------------------------------------------
module gregorian_julian_day_converter_core_test;

   localparam int unsigned YEAR_LIMIT  = gjdc_pkg::MAX_YEAR_DEF;
   localparam int          RAND_BEATS  = 950;
   localparam int          FLOOD_BEATS = 40;
   localparam int          HOLD_CYCLES = 80;

   typedef struct packed {
      logic        kind;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [22:0] day_number;
   } conv_req_type;

   typedef struct packed {
      conv_req_type      req;
      bit                typed;
      gjdc_pkg::res_type want;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [13:0] req_year;
   logic [3:0]  req_month;
   logic [4:0]  req_day;
   logic [22:0] req_day_number;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [22:0] rsp_out_day_number;
   logic [13:0] rsp_out_year;
   logic [3:0]  rsp_out_month;
   logic [4:0]  rsp_out_day;
   logic [2:0]  rsp_status;

   gjdc_pkg::res_type pending_results[$];
   int      errors;
   int      n_to_jdn;
   int      n_from_jdn;
   int      n_bad_status;
   bit      flood_start;

   gregorian_julian_day_converter_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_year           (req_year),
      .req_month          (req_month),
      .req_day            (req_day),
      .req_day_number     (req_day_number),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_day_number (rsp_out_day_number),
      .rsp_out_year       (rsp_out_year),
      .rsp_out_month      (rsp_out_month),
      .rsp_out_day        (rsp_out_day),
      .rsp_status         (rsp_status)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ------------------------------------------------------------------
   // Calendar model
   // ------------------------------------------------------------------
   function automatic int cal_month_len(input longint y, input longint m);
      int len;
      case (m)
         2:            len = ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 29 : 28;
         4, 6, 9, 11:  len = 30;
         1, 3, 5, 7, 8, 10, 12: len = 31;
         default:      len = 0;
      endcase
      return len;
   endfunction

   // Signed division truncates toward zero, so a is -1 for January and February
   function automatic longint greg_to_jdn(input longint y, input longint m, input longint d);
      longint a;
      a = (m - 14) / 12;
      return (1461 * (y + 4800 + a)) / 4 + (367 * (m - 2 - 12 * a)) / 12
           - (3 * ((y + 4900 + a) / 100)) / 4 + d - 32075;
   endfunction

   function automatic gjdc_pkg::res_type convert_date(input conv_req_type r);
      gjdc_pkg::res_type res;
      longint  y, m, d, dn, l, n, i, j, lo, hi;
      res = '0;
      y   = longint'(r.year);
      m   = longint'(r.month);
      d   = longint'(r.day);
      dn  = longint'(r.day_number);
      if (r.kind == gjdc_pkg::KIND_TO_JDN) begin
         if (y < 1 || y > YEAR_LIMIT) begin
            res.status = gjdc_pkg::ST_BAD_YEAR;
         end else if (m < 1 || m > 12) begin
            res.status = gjdc_pkg::ST_BAD_MONTH;
         end else if (d < 1 || d > cal_month_len(y, m)) begin
            res.status = gjdc_pkg::ST_BAD_DAY;
         end else begin
            res.day_number = 23'(greg_to_jdn(y, m, d));
            res.year       = r.year;
            res.month      = r.month;
            res.day        = r.day;
            res.status     = gjdc_pkg::ST_OK;
         end
      end else begin
         lo = greg_to_jdn(1, 1, 1);
         hi = greg_to_jdn(YEAR_LIMIT, 12, 31);
         if (dn < lo || dn > hi) begin
            res.status = gjdc_pkg::ST_BAD_DAYNUM;
         end else begin
            l = dn + 68569;
            n = (4 * l) / 146097;
            l = l - (146097 * n + 3) / 4;
            i = (4000 * (l + 1)) / 1461001;
            l = l - (1461 * i) / 4 + 31;
            j = (80 * l) / 2447;
            d = l - (2447 * j) / 80;
            l = j / 11;
            m = j + 2 - 12 * l;
            y = 100 * (n - 49) + i + l;
            res.day_number = r.day_number;
            res.year       = 14'(y);
            res.month      = 4'(m);
            res.day        = 5'(d);
            res.status     = gjdc_pkg::ST_OK;
         end
      end
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic offer(input conv_req_type r, input gjdc_pkg::res_type want);
      req_valid      <= 1'b1;
      req_kind       <= r.kind;
      req_year       <= r.year;
      req_month      <= r.month;
      req_day        <= r.day;
      req_day_number <= r.day_number;
      do
         @(posedge clock);
      while (req_stall);
      pending_results.push_back(want);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
   endtask

   dir_row_type dir_rows [25];

   initial begin
      conv_req_type      r;
      gjdc_pkg::res_type want;
      int        burst_left;
      int        gap;
      int        pick;
      longint    y, m;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = gjdc_pkg::KIND_TO_JDN;
      req_year       = '0;
      req_month      = '0;
      req_day        = '0;
      req_day_number = '0;
      flood_start    = 1'b0;

      dir_rows = '{
         // range edges of both directions
         '{'{gjdc_pkg::KIND_TO_JDN, 14'd1, 4'd1, 5'd1, 23'd0}, 1'b1,
           '{23'd1721426, 14'd1, 4'd1, 5'd1, gjdc_pkg::ST_OK}},
         '{'{gjdc_pkg::KIND_TO_JDN, 14'd9999, 4'd12, 5'd31, 23'd8388607}, 1'b1,
           '{23'd5373484, 14'd9999, 4'd12, 5'd31, gjdc_pkg::ST_OK}},
         '{'{gjdc_pkg::KIND_FROM_JDN, 14'd0, 4'd0, 5'd0, 23'd1721426}, 1'b1,
           '{23'd1721426, 14'd1, 4'd1, 5'd1, gjdc_pkg::ST_OK}},
         '{'{gjdc_pkg::KIND_FROM_JDN, 14'd16383, 4'd15, 5'd31, 23'd5373484}, 1'b1,
           '{23'd5373484, 14'd9999, 4'd12, 5'd31, gjdc_pkg::ST_OK}},
         '{'{gjdc_pkg::KIND_FROM_JDN, 14'd0, 4'd0, 5'd0, 23'd1721425}, 1'b1,
           '{23'd0, 14'd0, 4'd0, 5'd0, gjdc_pkg::ST_BAD_DAYNUM}},
         '{'{gjdc_pkg::KIND_FROM_JDN, 14'd0, 4'd0, 5'd0, 23'd5373485}, 1'b1,
           '{23'd0, 14'd0, 4'd0, 5'd0, gjdc_pkg::ST_BAD_DAYNUM}},
         '{'{gjdc_pkg::KIND_FROM_JDN, 14'd0, 4'd0, 5'd0, 23'd0}, 1'b1,
           '{23'd0, 14'd0, 4'd0, 5'd0, gjdc_pkg::ST_BAD_DAYNUM}},
         '{'{gjdc_pkg::KIND_FROM_JDN, 14'd16383, 4'd15, 5'd31, 23'd8388607}, 1'b1,
           '{23'd0, 14'd0, 4'd0, 5'd0, gjdc_pkg::ST_BAD_DAYNUM}},
         // year checked first, then month, then day
         '{'{gjdc_pkg::KIND_TO_JDN, 14'd0, 4'd1, 5'd1, 23'd0}, 1'b1,
           '{23'd0, 14'd0, 4'd0, 5'd0, gjdc_pkg::ST_BAD_YEAR}},
         '{'{gjdc_pkg::KIND_TO_JDN, 14'd10000, 4'd1, 5'd1, 23'd0}, 1'b1,
           '{23'd0, 14'd0, 4'd0, 5'd0, gjdc_pkg::ST_BAD_YEAR}},
         '{'{gjdc_pkg::KIND_TO_JDN, 14'd16383, 4'd15, 5'd31, 23'd8388607}, 1'b1,
           '{23'd0, 14'd0, 4'd0, 5'd0, gjdc_pkg::ST_BAD_YEAR}},
         '{'{gjdc_pkg::KIND_TO_JDN, 14'd0, 4'd0, 5'd0, 23'd0}, 1'b1,
           '{23'd0, 14'd0, 4'd0, 5'd0, gjdc_pkg::ST_BAD_YEAR}},
         '{'{gjdc_pkg::KIND_TO_JDN, 14'd2000, 4'd0, 5'd1, 23'd0}, 1'b1,
           '{23'd0, 14'd0, 4'd0, 5'd0, gjdc_pkg::ST_BAD_MONTH}},
         '{'{gjdc_pkg::KIND_TO_JDN, 14'd2000, 4'd13, 5'd1, 23'd0}, 1'b1,
           '{23'd0, 14'd0, 4'd0, 5'd0, gjdc_pkg::ST_BAD_MONTH}},
         '{'{gjdc_pkg::KIND_TO_JDN, 14'd2000, 4'd15, 5'd0, 23'd0}, 1'b1,
           '{23'd0, 14'd0, 4'd0, 5'd0, gjdc_pkg::ST_BAD_MONTH}},
         '{'{gjdc_pkg::KIND_TO_JDN, 14'd2000, 4'd1, 5'd0, 23'd0}, 1'b1,
           '{23'd0, 14'd0, 4'd0, 5'd0, gjdc_pkg::ST_BAD_DAY}},
         '{'{gjdc_pkg::KIND_TO_JDN, 14'd2001, 4'd2, 5'd29, 23'd0}, 1'b1,
           '{23'd0, 14'd0, 4'd0, 5'd0, gjdc_pkg::ST_BAD_DAY}},
         '{'{gjdc_pkg::KIND_TO_JDN, 14'd1900, 4'd2, 5'd29, 23'd0}, 1'b1,
           '{23'd0, 14'd0, 4'd0, 5'd0, gjdc_pkg::ST_BAD_DAY}},
         '{'{gjdc_pkg::KIND_TO_JDN, 14'd2000, 4'd4, 5'd31, 23'd0}, 1'b1,
           '{23'd0, 14'd0, 4'd0, 5'd0, gjdc_pkg::ST_BAD_DAY}},
         // leap days and early months, against the model
         '{'{gjdc_pkg::KIND_TO_JDN, 14'd2000, 4'd2, 5'd29, 23'd0}, 1'b0, '0},
         '{'{gjdc_pkg::KIND_TO_JDN, 14'd2004, 4'd2, 5'd29, 23'd0}, 1'b0, '0},
         '{'{gjdc_pkg::KIND_TO_JDN, 14'd2000, 4'd1, 5'd1, 23'd0}, 1'b0, '0},
         '{'{gjdc_pkg::KIND_TO_JDN, 14'd1, 4'd2, 5'd28, 23'd0}, 1'b0, '0},
         '{'{gjdc_pkg::KIND_FROM_JDN, 14'd0, 4'd0, 5'd0, 23'd2451545}, 1'b0, '0},
         '{'{gjdc_pkg::KIND_FROM_JDN, 14'd0, 4'd0, 5'd0, 23'd2299161}, 1'b0, '0}
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (dir_rows[k]) begin
         r    = dir_rows[k].req;
         want = dir_rows[k].typed ? dir_rows[k].want : convert_date(r);
         offer(r, want);
         if ($urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      drain_results();

      // Back-to-back beats first while the result side holds off
      flood_start = 1'b1;
      burst_left  = FLOOD_BEATS;
      for (int n = 0; n < RAND_BEATS; n++) begin
         r.day_number = 23'($urandom);
         r.year       = 14'($urandom);
         r.month      = 4'($urandom);
         r.day        = 5'($urandom);
         pick         = $urandom_range(0, 99);
         if (pick < 45) begin
            r.kind = gjdc_pkg::KIND_TO_JDN;
            case ($urandom_range(0, 3))
               0:       y = 100 * $urandom_range(1, 99);
               1:       y = $urandom_range(1, 20);
               2:       y = $urandom_range(9980, YEAR_LIMIT);
               default: y = $urandom_range(1, YEAR_LIMIT);
            endcase
            m       = $urandom_range(0, 4) == 0 ? 2 : $urandom_range(1, 12);
            r.year  = 14'(y);
            r.month = 4'(m);
            r.day   = $urandom_range(0, 3) == 0 ? 5'(cal_month_len(y, m))
                                              : 5'($urandom_range(1, cal_month_len(y, m)));
         end else if (pick < 55) begin
            r.kind = gjdc_pkg::KIND_TO_JDN;
         end else if (pick < 88) begin
            r.kind = gjdc_pkg::KIND_FROM_JDN;
            case ($urandom_range(0, 5))
               0:       r.day_number = 23'(gjdc_pkg::LO_DN + $urandom_range(0, 400));
               1:       r.day_number = 23'(5373484 - $urandom_range(0, 400));
               default: r.day_number = 23'($urandom_range(gjdc_pkg::LO_DN, 5373484));
            endcase
         end else begin
            r.kind = gjdc_pkg::KIND_FROM_JDN;
         end
         offer(r, convert_date(r));

         if (n == RAND_BEATS / 2) begin
            drain_results();
         end else if (n >= FLOOD_BEATS) begin
            if (burst_left > 0)
               burst_left--;
            if (burst_left == 0) begin
               gap = $urandom_range(0, 7) == 0 ? $urandom_range(5, 12) : $urandom_range(0, 4);
               if (gap > 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(negedge clock);
               end
               burst_left = $urandom_range(0, 5) == 0 ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 20);
            end
         end
      end
      drain_results();
      repeat (3 * gjdc_pkg::STAGES) @(negedge clock);

      $display("Covered %0d date beats and %0d day number beats, %0d with an error status.",
               n_to_jdn, n_from_jdn, n_bad_status);
      $display("Traffic included a long result hold-off, bursts, gaps and three full drains.");
      if (errors == 0)
         $display("gregorian_julian_day_converter_core_test: done, clean");
      else
         $display("gregorian_julian_day_converter_core_test: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------
   // Result side: stall pattern with one long hold-off
   // ------------------------------------------------------------------
   initial begin
      int mode;
      int mode_left;
      int hold_left;
      bit held;
      rsp_stall = 1'b0;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(negedge clock);
         if (flood_start && !held) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 9) < 3);
               2:       rsp_stall <= ~rsp_stall;
               default: rsp_stall <= ($urandom_range(0, 9) < 7);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Result check
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      gjdc_pkg::res_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result beat: day_number %0d status %0d",
                   rsp_out_day_number, rsp_status);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (want.status != gjdc_pkg::ST_OK)
               n_bad_status++;
            if (rsp_out_day_number != want.day_number) begin
               $error("out_day_number: expected %0d, got %0d", want.day_number,
                      rsp_out_day_number);
               errors++;
            end
            if (rsp_out_year != want.year) begin
               $error("out_year: expected %0d, got %0d", want.year, rsp_out_year);
               errors++;
            end
            if (rsp_out_month != want.month) begin
               $error("out_month: expected %0d, got %0d", want.month, rsp_out_month);
               errors++;
            end
            if (rsp_out_day != want.day) begin
               $error("out_day: expected %0d, got %0d", want.day, rsp_out_day);
               errors++;
            end
            if (rsp_status != want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
         end
      end
   end

   // Count request kinds as they are accepted
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         if (req_kind == gjdc_pkg::KIND_TO_JDN)
            n_to_jdn++;
         else
            n_from_jdn++;
      end
   end

   initial begin
      #2000000;
      $display("gregorian_julian_day_converter_core_test: done, errors");
      $finish;
   end

endmodule
